@@ hw/rtl/dts_pkg.sv @@
// ----------------------------------------------------------------------------
// dts_pkg
// shared types and constants of the deadline timer scheduler
// ----------------------------------------------------------------------------
`default_nettype none
package dts_pkg;

    localparam int TW = 48;

    typedef enum logic [2:0] {
        CMD_ADD_REL = 3'd0,
        CMD_ADD_ABS = 3'd1,
        CMD_DELETE  = 3'd2,
        CMD_CANCEL  = 3'd3,
        CMD_TICK    = 3'd4,
        CMD_QUERY   = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        EV_ADDED     = 3'd0,
        EV_FULL      = 3'd1,
        EV_DELETED   = 3'd2,
        EV_CANCELLED = 3'd3,
        EV_QUERY     = 3'd4,
        EV_FIRED     = 3'd5,
        EV_TICK_DONE = 3'd6
    } ev_t;

    localparam logic [5:0] LIMIT_RESET = 6'd49;
    localparam logic [1:0] REG_MAX_FIRES = 2'd0;

    typedef struct packed {
        logic [2:0]    command;
        logic [31:0]   timer_id;
        logic [TW-1:0] delay;
        logic [TW-1:0] period;
        logic [7:0]    timer_kind;
        logic [31:0]   user_data;
        logic [TW-1:0] now_time;
    } req_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic        found;
        logic [31:0] out_id;
        logic [7:0]  out_kind;
        logic [31:0] out_data;
        logic        one_shot;
        logic        drained;
        logic        last;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic latch;      // capture request, clear scan state
        logic scan;       // visit one slot
        logic do_add;     // write found free slot
        logic do_remove;  // clear valid of hit slot
        logic do_fire;    // re-arm or free best slot
        logic count_fire;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic hit;        // id match or free slot or due slot found
        logic limit_hit;  // fired count equals limit
    } dp_sts_t;

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW] ? {TW{1'b1}} : s[TW-1:0];
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/dts_datapath.sv @@
// ----------------------------------------------------------------------------
// dts_datapath
// slot table memories, scan logic and result formatting
// ----------------------------------------------------------------------------
`default_nettype none
module dts_datapath
    import dts_pkg::*;
#(
    parameter int SLOTS = 64
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire req_t     req,
    input  wire logic [5:0] limit,
    input  wire dp_cmd_t  cmd,
    output dp_sts_t       sts,
    output rsp_t          fire_rsp,
    output rsp_t          done_rsp
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0] valid_reg;
    logic [TW-1:0] dl_mem  [SLOTS];
    logic [TW-1:0] per_mem [SLOTS];
    logic [31:0]   id_mem  [SLOTS];
    logic [7:0]    kind_mem[SLOTS];
    logic [31:0]   pay_mem [SLOTS];
    logic [31:0]   ord_mem [SLOTS];

    req_t          req_reg;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] rd_idx;
    logic          rd_vld_reg;
    logic [AW-1:0] rd_slot_reg;
    logic [TW-1:0] rd_dl_reg, rd_per_reg;
    logic [31:0]   rd_id_reg, rd_ord_reg, rd_pay_reg;
    logic [7:0]    rd_kind_reg;
    logic          hit_reg;
    logic [AW-1:0] hit_slot_reg;
    logic [TW-1:0] best_dl_reg, best_per_reg;
    logic [31:0]   best_ord_reg, best_id_reg, best_pay_reg;
    logic [7:0]    best_kind_reg;
    logic [31:0]   next_id_reg, order_reg;
    logic [5:0]    fired_reg;
    logic          scan_last_reg;

    logic [31:0] new_id;
    logic        is_add, is_tick, cand;

    assign is_add  = (req_reg.command == CMD_ADD_REL) || (req_reg.command == CMD_ADD_ABS);
    assign is_tick = (req_reg.command == CMD_TICK);
    assign new_id  = (next_id_reg + 32'd1 == 32'd0) ? 32'd1 : next_id_reg + 32'd1;
    assign rd_idx  = idx_reg;

    // one registered read per cycle; compare on the following cycle
    always_comb
    begin
        cand = 1'b0;
        if (rd_vld_reg)
        begin
            if (is_add)
                cand = !valid_reg[rd_slot_reg] && !hit_reg;
            else if (is_tick)
                cand = valid_reg[rd_slot_reg] && (rd_dl_reg <= req_reg.now_time) &&
                       (!hit_reg || rd_dl_reg < best_dl_reg ||
                        (rd_dl_reg == best_dl_reg && rd_ord_reg < best_ord_reg));
            else
                cand = valid_reg[rd_slot_reg] && (rd_id_reg == req_reg.timer_id) && !hit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            req_reg <= req;
        rd_dl_reg   <= dl_mem[rd_idx];
        rd_per_reg  <= per_mem[rd_idx];
        rd_id_reg   <= id_mem[rd_idx];
        rd_kind_reg <= kind_mem[rd_idx];
        rd_pay_reg  <= pay_mem[rd_idx];
        rd_ord_reg  <= ord_mem[rd_idx];
        rd_slot_reg <= rd_idx;
        if (cand)
        begin
            hit_slot_reg  <= rd_slot_reg;
            best_dl_reg   <= rd_dl_reg;
            best_per_reg  <= rd_per_reg;
            best_ord_reg  <= rd_ord_reg;
            best_id_reg   <= rd_id_reg;
            best_kind_reg <= rd_kind_reg;
            best_pay_reg  <= rd_pay_reg;
        end
        if (cmd.do_add)
        begin
            dl_mem[hit_slot_reg]   <= (req_reg.command == CMD_ADD_REL) ?
                                      sat_add(req_reg.now_time, req_reg.delay) : req_reg.delay;
            per_mem[hit_slot_reg]  <= req_reg.period;
            id_mem[hit_slot_reg]   <= new_id;
            kind_mem[hit_slot_reg] <= req_reg.timer_kind;
            pay_mem[hit_slot_reg]  <= req_reg.user_data;
            ord_mem[hit_slot_reg]  <= order_reg;
        end
        else if (cmd.do_fire && best_per_reg != '0)
        begin
            dl_mem[hit_slot_reg]  <= sat_add(req_reg.now_time, best_per_reg);
            ord_mem[hit_slot_reg] <= order_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            next_id_reg   <= '0;
            order_reg     <= '0;
            fired_reg     <= '0;
            scan_last_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg    <= cmd.scan;
            scan_last_reg <= cmd.scan && (idx_reg == AW'(SLOTS - 1));
            if (cand)
                hit_reg <= 1'b1;
            if (cmd.scan)
                idx_reg <= (idx_reg == AW'(SLOTS - 1)) ? '0 : idx_reg + AW'(1);
            if (cmd.latch)
                fired_reg <= '0;
            if (cmd.latch || cmd.do_fire)
            begin
                hit_reg <= 1'b0;
                idx_reg <= '0;
            end
            if (cmd.do_add)
            begin
                valid_reg[hit_slot_reg] <= 1'b1;
                next_id_reg <= new_id;
                order_reg   <= order_reg + 32'd1;
            end
            if (cmd.do_remove)
                valid_reg[hit_slot_reg] <= 1'b0;
            if (cmd.do_fire)
            begin
                if (best_per_reg == '0)
                    valid_reg[hit_slot_reg] <= 1'b0;
                else
                    order_reg <= order_reg + 32'd1;
            end
            if (cmd.count_fire)
                fired_reg <= fired_reg + 6'd1;
        end
    end

    // high while the last slot read is being compared
    assign sts.scan_last = scan_last_reg;
    assign sts.hit       = hit_reg;
    assign sts.limit_hit = (fired_reg == limit);

    // response for the non-tick commands and for fired events, and the tick done response
    always_comb
    begin
        fire_rsp = '0;
        fire_rsp.last = 1'b1;
        case (req_reg.command)
            CMD_ADD_REL, CMD_ADD_ABS:
            begin
                fire_rsp.event_kind = hit_reg ? EV_ADDED : EV_FULL;
                fire_rsp.out_id     = hit_reg ? new_id : '0;
                fire_rsp.out_kind   = hit_reg ? req_reg.timer_kind : '0;
            end
            CMD_DELETE, CMD_CANCEL, CMD_QUERY:
            begin
                fire_rsp.event_kind = (req_reg.command == CMD_DELETE) ? EV_DELETED :
                                      (req_reg.command == CMD_CANCEL) ? EV_CANCELLED : EV_QUERY;
                fire_rsp.found    = hit_reg;
                fire_rsp.out_id   = req_reg.timer_id;
                fire_rsp.out_kind = hit_reg ? best_kind_reg : '0;
            end
            default:
            begin
                fire_rsp.event_kind = EV_FIRED;
                fire_rsp.out_id     = best_id_reg;
                fire_rsp.out_kind   = best_kind_reg;
                fire_rsp.out_data   = best_pay_reg;
                fire_rsp.one_shot   = (best_per_reg == '0);
                fire_rsp.last       = 1'b0;
            end
        endcase
        done_rsp = '0;
        done_rsp.event_kind = EV_TICK_DONE;
        done_rsp.drained    = (fired_reg != limit);
        done_rsp.last       = 1'b1;
    end
endmodule
`default_nettype wire

@@ hw/rtl/dts_ctrl.sv @@
// ----------------------------------------------------------------------------
// dts_ctrl
// command sequencer of the deadline timer scheduler
// ----------------------------------------------------------------------------
`default_nettype none
module dts_ctrl
    import dts_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic [2:0] command,
    input  wire logic [2:0] cur_cmd,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd,
    output logic         busy,
    output logic         strobe,
    output logic         sel_done
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_WAIT = 5'b00100,
        S_EMIT = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_cmd;
    logic   tick;

    assign valid_cmd = (command inside {CMD_ADD_REL, CMD_ADD_ABS, CMD_DELETE,
                                        CMD_CANCEL, CMD_TICK, CMD_QUERY});
    assign tick = (cur_cmd == CMD_TICK);
    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        strobe     = 1'b0;
        sel_done   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start && valid_cmd)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tick && sts.limit_hit)
                    state_next = S_DONE;
                else if (sts.scan_last)
                    state_next = S_WAIT;
                else
                    cmd.scan = 1'b1;
            end
            S_WAIT:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (tick)
                begin
                    if (sts.hit)
                    begin
                        strobe         = 1'b1;
                        cmd.do_fire    = 1'b1;
                        cmd.count_fire = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else
                        state_next = S_DONE;
                end
                else
                begin
                    strobe        = 1'b1;
                    cmd.do_add    = sts.hit && (cur_cmd == CMD_ADD_REL || cur_cmd == CMD_ADD_ABS);
                    cmd.do_remove = sts.hit && (cur_cmd == CMD_DELETE || cur_cmd == CMD_CANCEL);
                    state_next    = S_IDLE;
                end
            end
            S_DONE:
            begin
                strobe     = 1'b1;
                sel_done   = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

@@ hw/rtl/deadline_timer_scheduler.sv @@
// ----------------------------------------------------------------------------
// deadline_timer_scheduler
// timer slot table with add, delete, cancel, query and tick commands
// ----------------------------------------------------------------------------
// channel   ports                      handshake
// request   start, req                 taken when start, not busy and command valid
// result    rsp, strobe                one cycle per result, no backpressure
// config    psel..pready               apb write, pready always high
//
// every command, but a tick with a limit of zero, scans all slots, one memory
// read a cycle; no new request is taken until its result has been shown
// a tick rescans all slots after each timer it fires, then ends with a closing
// scan and tick done, or goes straight to tick done when the limit is reached
// reset clears all valid bits at once, so no clearing pass is needed
// busy stays high until the last result has been shown
// ----------------------------------------------------------------------------
`default_nettype none
module deadline_timer_scheduler
    import dts_pkg::*;
#(
    parameter int SLOTS = 64
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire req_t        req,
    output logic             busy,
    output logic             strobe,
    output rsp_t             rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [5:0] limit_reg;
    dp_cmd_t    dcmd;
    dp_sts_t    dsts;
    rsp_t       fire_rsp, done_rsp;
    logic       sel_done;
    logic [2:0] cur_cmd_reg;

    // limit register, single word at address zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (psel && penable && pwrite && paddr == REG_MAX_FIRES)
            limit_reg <= pwdata[5:0];
    end
    assign pready = 1'b1;
    assign prdata = (paddr == REG_MAX_FIRES) ? {26'd0, limit_reg} : 32'd0;

    // command held for the controller's view of the active request
    always_ff @(posedge clk)
    begin
        if (dcmd.latch)
            cur_cmd_reg <= req.command;
    end

    dts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .command  (req.command),
        .cur_cmd  (cur_cmd_reg),
        .sts      (dsts),
        .cmd      (dcmd),
        .busy     (busy),
        .strobe   (strobe),
        .sel_done (sel_done)
    );

    dts_datapath #(.SLOTS(SLOTS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .limit    (limit_reg),
        .cmd      (dcmd),
        .sts      (dsts),
        .fire_rsp (fire_rsp),
        .done_rsp (done_rsp)
    );

    assign rsp = sel_done ? done_rsp : fire_rsp;
endmodule
`default_nettype wire
